/* hdl/ib_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ib_pkg - shared types and constants for the interval bounds arithmetic block
// Operation codes, field widths and the words passed between pipeline stages.
// ----------------------------------------------------------------------------
package ib_pkg;

	// bits of each bound that take part in the arithmetic (8 .. IN_W)
	localparam int VALUE_WIDTH = 32;
	// port widths of the operand and result bounds
	localparam int IN_W        = 32;
	localparam int OUT_W       = 2 * IN_W;
	localparam int MODE_W      = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD = 3'd0,
		MODE_SUB = 3'd1,
		MODE_MUL = 3'd2,
		MODE_DIV = 3'd3,
		MODE_MOD = 3'd4
	} mode_t;

	typedef logic signed [IN_W-1:0]  in_val_t;
	typedef logic signed [OUT_W-1:0] out_val_t;

	// stage 1: decoded operands
	typedef struct packed {
		mode_t   mode;
		logic    has;
		logic    lnull;
		logic    rnull;
		logic    lint;
		logic    rint;
		in_val_t lmin;
		in_val_t lmax;
		in_val_t rmin;
		in_val_t rmax;
	} op_t;

	// stage 2: corner values or a fixed range
	typedef struct packed {
		logic     has;
		logic     cnull;
		logic     corner;
		out_val_t c0;
		out_val_t c1;
		out_val_t c2;
		out_val_t c3;
		out_val_t fix_lo;
		out_val_t fix_hi;
	} corner_t;

	// stage 3: first level of the min / max tree
	typedef struct packed {
		logic     has;
		logic     cnull;
		logic     corner;
		out_val_t lo_a;
		out_val_t lo_b;
		out_val_t hi_a;
		out_val_t hi_b;
		out_val_t fix_lo;
		out_val_t fix_hi;
	} pair_t;

	// stage 4: result word
	typedef struct packed {
		logic     has;
		logic     cnull;
		out_val_t lo;
		out_val_t hi;
	} res_t;

	// low VALUE_WIDTH bits read as two's complement
	function automatic in_val_t sext_value(input logic [IN_W-1:0] x);
		logic signed [VALUE_WIDTH-1:0] t;
		t = x[VALUE_WIDTH-1:0];
		return IN_W'(t);
	endfunction

	function automatic out_val_t widen(input in_val_t x);
		return OUT_W'(x);
	endfunction

	function automatic out_val_t abs_wide(input out_val_t x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic out_val_t min_wide(input out_val_t a, input out_val_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic out_val_t max_wide(input out_val_t a, input out_val_t b);
		return (a > b) ? a : b;
	endfunction

endpackage
`default_nettype wire

/* hdl/ib_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ib_in_if / ib_out_if - operand and result channels
// Valid / ready channels; a word moves on an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface ib_in_if;
	logic                         valid;
	logic                         ready;
	logic [ib_pkg::MODE_W-1:0]    mode;
	logic                         left_has_stats;
	logic                         left_can_null;
	logic                         left_integral;
	logic signed [ib_pkg::IN_W-1:0] left_min;
	logic signed [ib_pkg::IN_W-1:0] left_max;
	logic                         right_has_stats;
	logic                         right_can_null;
	logic                         right_integral;
	logic signed [ib_pkg::IN_W-1:0] right_min;
	logic signed [ib_pkg::IN_W-1:0] right_max;

	modport source (
		output valid, mode, left_has_stats, left_can_null, left_integral,
		       left_min, left_max, right_has_stats, right_can_null,
		       right_integral, right_min, right_max,
		input  ready
	);
	modport sink (
		input  valid, mode, left_has_stats, left_can_null, left_integral,
		       left_min, left_max, right_has_stats, right_can_null,
		       right_integral, right_min, right_max,
		output ready
	);
endinterface

interface ib_out_if;
	logic                            valid;
	logic                            ready;
	logic                            out_has_stats;
	logic                            out_can_null;
	logic signed [ib_pkg::OUT_W-1:0] out_min;
	logic signed [ib_pkg::OUT_W-1:0] out_max;

	modport source (
		output valid, out_has_stats, out_can_null, out_min, out_max,
		input  ready
	);
	modport sink (
		input  valid, out_has_stats, out_can_null, out_min, out_max,
		output ready
	);
endinterface
`default_nettype wire

/* hdl/ib_corner.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ib_corner - corner evaluation stage
// Forms the four corner sums, differences or products, or the fixed range
// of divide and modulo, and registers them in stage 2.
// ----------------------------------------------------------------------------
module ib_corner (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire ib_pkg::op_t    in_word,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ib_pkg::corner_t     out_word
);

	logic            v_s2;
	ib_pkg::corner_t word_s2;
	ib_pkg::corner_t nxt;

	ib_pkg::out_val_t lmin_w, lmax_w, rmin_w, rmax_w, mag;

	// widened operands and left magnitude for divide
	always_comb begin
		lmin_w = ib_pkg::widen(in_word.lmin);
		lmax_w = ib_pkg::widen(in_word.lmax);
		rmin_w = ib_pkg::widen(in_word.rmin);
		rmax_w = ib_pkg::widen(in_word.rmax);
		mag    = ib_pkg::max_wide(ib_pkg::abs_wide(lmin_w), ib_pkg::abs_wide(lmax_w));
	end

	// per-operation corners
	always_comb begin
		nxt        = '0;
		nxt.has    = in_word.has;
		nxt.cnull  = in_word.lnull | in_word.rnull;
		nxt.corner = 1'b1;
		case (in_word.mode)
			ib_pkg::MODE_ADD: begin
				nxt.c0 = lmin_w + rmin_w;
				nxt.c1 = lmin_w + rmax_w;
				nxt.c2 = lmax_w + rmin_w;
				nxt.c3 = lmax_w + rmax_w;
			end
			ib_pkg::MODE_SUB: begin
				nxt.c0 = lmin_w - rmin_w;
				nxt.c1 = lmin_w - rmax_w;
				nxt.c2 = lmax_w - rmin_w;
				nxt.c3 = lmax_w - rmax_w;
			end
			ib_pkg::MODE_MUL: begin
				// 32x32 signed products, full width result
				nxt.c0 = in_word.lmin * in_word.rmin;
				nxt.c1 = in_word.lmin * in_word.rmax;
				nxt.c2 = in_word.lmax * in_word.rmin;
				nxt.c3 = in_word.lmax * in_word.rmax;
			end
			ib_pkg::MODE_DIV: begin
				nxt.corner = 1'b0;
				nxt.has    = in_word.has & in_word.lint & in_word.rint;
				// divisor range spanning zero may yield null
				if ((in_word.rmin <= 0) && (in_word.rmax >= 0)) begin
					nxt.cnull = 1'b1;
				end
				nxt.fix_lo = -mag;
				nxt.fix_hi = mag;
			end
			ib_pkg::MODE_MOD: begin
				nxt.corner = 1'b0;
				nxt.fix_lo = '0;
				nxt.fix_hi = rmax_w;
			end
			default: begin
				nxt.corner = 1'b0;
				nxt.has    = 1'b0;
			end
		endcase
	end

	assign in_ready  = !v_s2 || out_ready;
	assign out_valid = v_s2;
	assign out_word  = word_s2;

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s2 <= nxt;
		end
	end

endmodule
`default_nettype wire

/* hdl/ib_reduce.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ib_reduce - min / max reduction and result register
// Stage 3 takes pairwise min / max of the corners, stage 4 finishes the tree,
// picks the fixed range where no corners apply and zeroes words without stats.
// ----------------------------------------------------------------------------
module ib_reduce (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire ib_pkg::corner_t   in_word,
	ib_out_if.source               result
);

	logic            v_s3, v_s4;
	logic            rdy_s3, rdy_s4;
	ib_pkg::pair_t   word_s3, nxt3;
	ib_pkg::res_t    word_s4, nxt4;

	// first tree level
	always_comb begin
		nxt3.has    = in_word.has;
		nxt3.cnull  = in_word.cnull;
		nxt3.corner = in_word.corner;
		nxt3.lo_a   = ib_pkg::min_wide(in_word.c0, in_word.c1);
		nxt3.lo_b   = ib_pkg::min_wide(in_word.c2, in_word.c3);
		nxt3.hi_a   = ib_pkg::max_wide(in_word.c0, in_word.c1);
		nxt3.hi_b   = ib_pkg::max_wide(in_word.c2, in_word.c3);
		nxt3.fix_lo = in_word.fix_lo;
		nxt3.fix_hi = in_word.fix_hi;
	end

	// second tree level, range select, no-stats zeroing
	always_comb begin
		nxt4.has = word_s3.has;
		if (word_s3.corner) begin
			nxt4.lo = ib_pkg::min_wide(word_s3.lo_a, word_s3.lo_b);
			nxt4.hi = ib_pkg::max_wide(word_s3.hi_a, word_s3.hi_b);
		end else begin
			nxt4.lo = word_s3.fix_lo;
			nxt4.hi = word_s3.fix_hi;
		end
		nxt4.cnull = word_s3.cnull;
		if (!word_s3.has) begin
			nxt4.cnull = 1'b0;
			nxt4.lo    = '0;
			nxt4.hi    = '0;
		end
	end

	assign rdy_s4   = !v_s4 || result.ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				v_s3 <= in_valid;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) begin
			word_s3 <= nxt3;
		end
		if (rdy_s4 && v_s3) begin
			word_s4 <= nxt4;
		end
	end

	assign result.valid         = v_s4;
	assign result.out_has_stats = word_s4.has;
	assign result.out_can_null  = word_s4.cnull;
	assign result.out_min       = word_s4.lo;
	assign result.out_max       = word_s4.hi;

	// a stalled stage 3 word is held for the output register
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !rdy_s4 |=> v_s3 && $stable(word_s3))
		else $error("stage 3 word changed during stall");

	// pairwise tree is ordered
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && word_s3.corner |-> (word_s3.lo_a <= word_s3.hi_a) &&
		(word_s3.lo_b <= word_s3.hi_b))
		else $error("corner pair out of order");

	// result without stats is all zero
	a_no_stats_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !word_s4.has |-> !word_s4.cnull && (word_s4.lo == 0) &&
		(word_s4.hi == 0))
		else $error("result without stats not cleared");

	// stage 3 word reaches the output when the output slot frees
	a_s4_fill: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && rdy_s4 |=> v_s4)
		else $error("stage 3 word lost on advance");

endmodule
`default_nettype wire

/* hdl/interval_bounds_arith.sv */
`timescale 1ns / 1ps
`default_nettype none
// A word accepted on the operand channel passes four register stages to the result
// channel: operand decode, corners, pair min/max, result. The 32x32 corner multipliers
// sit alone in stage 2. Throughput: one word per cycle unless the output stalls.
// Backpressure holds each stage in place; every stage refills as soon as it moves on.
// Reset: arst_n clears all stage valid bits at once; the payload registers are not reset.
// ----------------------------------------------------------------------------
// interval_bounds_arith - range propagation for one binary arithmetic operation
// Takes two signed ranges with stats / null / integral flags and an operation,
// returns the range of the result in twice the operand width.
// ----------------------------------------------------------------------------
module interval_bounds_arith (
	input  wire logic clk,
	input  wire logic arst_n,
	ib_in_if.sink     operands,
	ib_out_if.source  result
);

	logic            v_s1;
	logic            rdy_s1;
	logic            rdy_c;
	ib_pkg::op_t     word_s1, nxt1;
	logic            v_c;
	ib_pkg::corner_t word_c;
	logic            rdy_r;

	// operand decode
	always_comb begin
		nxt1.mode  = ib_pkg::mode_t'(operands.mode);
		nxt1.has   = operands.left_has_stats & operands.right_has_stats;
		nxt1.lnull = operands.left_can_null;
		nxt1.rnull = operands.right_can_null;
		nxt1.lint  = operands.left_integral;
		nxt1.rint  = operands.right_integral;
		nxt1.lmin  = ib_pkg::sext_value(operands.left_min);
		nxt1.lmax  = ib_pkg::sext_value(operands.left_max);
		nxt1.rmin  = ib_pkg::sext_value(operands.right_min);
		nxt1.rmax  = ib_pkg::sext_value(operands.right_max);
	end

	assign rdy_s1         = !v_s1 || rdy_c;
	assign operands.ready = rdy_s1;

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= operands.valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (rdy_s1 && operands.valid) begin
			word_s1 <= nxt1;
		end
	end

	ib_corner u_corner (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (rdy_c),
		.in_word   (word_s1),
		.out_valid (v_c),
		.out_ready (rdy_r),
		.out_word  (word_c)
	);

	ib_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_c),
		.in_ready (rdy_r),
		.in_word  (word_c),
		.result   (result)
	);

endmodule
`default_nettype wire

/* test/tb_interval_bounds_arith.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_bounds_arith - regression for the interval bounds arithmetic block
// Drives operand range pairs over the valid / ready input channel in random
// bursts, predicts each result range in the bench and checks every result
// word in order while the result channel stalls on its own random pattern.
// ----------------------------------------------------------------------------
module tb_interval_bounds_arith;

	localparam int IN_W        = ib_pkg::IN_W;
	localparam int OUT_W       = ib_pkg::OUT_W;
	localparam int VW          = ib_pkg::VALUE_WIDTH;
	localparam int MODE_CODES  = 1 << ib_pkg::MODE_W;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 12;

	localparam logic [IN_W-1:0] BOUND_MIN = {1'b1, {(IN_W-1){1'b0}}};
	localparam logic [IN_W-1:0] BOUND_MAX = {1'b0, {(IN_W-1){1'b1}}};

	// one operand word as the sender sees it
	typedef struct {
		logic [ib_pkg::MODE_W-1:0] mode;
		logic                      lhs;
		logic                      lnull;
		logic                      lint;
		logic [IN_W-1:0]           lmin;
		logic [IN_W-1:0]           lmax;
		logic                      rhs;
		logic                      rnull;
		logic                      rint;
		logic [IN_W-1:0]           rmin;
		logic [IN_W-1:0]           rmax;
	} operand_word_t;

	// one result word
	typedef struct {
		logic            has;
		logic            cnull;
		logic [OUT_W-1:0] lo;
		logic [OUT_W-1:0] hi;
	} range_word_t;

	logic clk;
	logic arst_n;

	ib_in_if  opnd_if ();
	ib_out_if res_if ();

	interval_bounds_arith DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (opnd_if),
		.result   (res_if)
	);

	range_word_t expected_ranges[$];
	range_word_t want;
	int          errors      = 0;
	int          words_sent  = 0;
	int          words_seen  = 0;
	int          cycle_count = 0;
	int          mode_count[MODE_CODES];

	// sender burst state
	int burst_left = 0;

	// receiver stall state
	int sink_style = 0;
	int style_left = 0;
	int stall_left = 0;

	// ------------------------------------------------------------------
	// clock and cycle limit
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_ranges.size());
			$display("interval_bounds_arith regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// range predictor
	function automatic longint bound_value(input logic [IN_W-1:0] x);
		logic [63:0] mask;
		logic [63:0] v;
		mask = (VW >= 64) ? ~64'd0 : ((64'd1 << VW) - 64'd1);
		v = {{(64-IN_W){1'b0}}, x} & mask;
		if (v[VW-1])
			v = v | ~mask;
		return longint'(v);
	endfunction

	function automatic longint lmin2(input longint a, input longint b);
		return (a < b) ? a : b;
	endfunction

	function automatic longint lmax2(input longint a, input longint b);
		return (a > b) ? a : b;
	endfunction

	function automatic range_word_t predict_range(input operand_word_t w);
		range_word_t r;
		longint      a0, a1, b0, b1;
		longint      c[4];
		longint      lo, hi;
		logic        has, cnull, corner;
		a0 = bound_value(w.lmin);
		a1 = bound_value(w.lmax);
		b0 = bound_value(w.rmin);
		b1 = bound_value(w.rmax);
		has = w.lhs && w.rhs;
		cnull = w.lnull || w.rnull;
		corner = 1'b0;
		lo = 0;
		hi = 0;
		if (has) begin
			case (w.mode)
				ib_pkg::MODE_ADD: begin
					c[0] = a0 + b0; c[1] = a0 + b1; c[2] = a1 + b0; c[3] = a1 + b1;
					corner = 1'b1;
				end
				ib_pkg::MODE_SUB: begin
					c[0] = a0 - b0; c[1] = a0 - b1; c[2] = a1 - b0; c[3] = a1 - b1;
					corner = 1'b1;
				end
				ib_pkg::MODE_MUL: begin
					c[0] = a0 * b0; c[1] = a0 * b1; c[2] = a1 * b0; c[3] = a1 * b1;
					corner = 1'b1;
				end
				ib_pkg::MODE_DIV: begin
					if (!w.lint || !w.rint) begin
						has = 1'b0;
					end else begin
						if (b0 <= 0 && b1 >= 0)
							cnull = 1'b1;
						hi = lmax2((a0 < 0) ? -a0 : a0, (a1 < 0) ? -a1 : a1);
						lo = -hi;
					end
				end
				ib_pkg::MODE_MOD: begin
					lo = 0;
					hi = b1;
				end
				default: has = 1'b0;
			endcase
		end
		if (corner) begin
			lo = lmin2(lmin2(c[0], c[1]), lmin2(c[2], c[3]));
			hi = lmax2(lmax2(c[0], c[1]), lmax2(c[2], c[3]));
		end
		if (!has) begin
			cnull = 1'b0;
			lo = 0;
			hi = 0;
		end
		r.has = has;
		r.cnull = cnull;
		r.lo = lo;
		r.hi = hi;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// error reporting
	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		errors++;
	endtask

	// ------------------------------------------------------------------
	// result checker: every accepted word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_ranges.size() == 0) begin
				report_error($sformatf("result word with nothing expected (min %0d max %0d)",
					res_if.out_min, res_if.out_max));
			end else begin
				want = expected_ranges.pop_front();
				if (res_if.out_has_stats !== want.has)
					report_error($sformatf("word %0d known flag: got %b expected %b",
						words_seen, res_if.out_has_stats, want.has));
				if (res_if.out_can_null !== want.cnull)
					report_error($sformatf("word %0d can_null: got %b expected %b",
						words_seen, res_if.out_can_null, want.cnull));
				if (res_if.out_min !== want.lo)
					report_error($sformatf("word %0d min: got %0d expected %0d",
						words_seen, res_if.out_min, $signed(want.lo)));
				if (res_if.out_max !== want.hi)
					report_error($sformatf("word %0d max: got %0d expected %0d",
						words_seen, res_if.out_max, $signed(want.hi)));
			end
			words_seen++;
		end
	end

	// ------------------------------------------------------------------
	// result ready: styles switch now and then; stalls of several lengths
	always @(negedge clk) begin
		if (style_left == 0) begin
			sink_style <= $urandom_range(0, 3);
			style_left <= $urandom_range(16, 200);
		end else begin
			style_left <= style_left - 1;
		end
		if (stall_left > 0) begin
			res_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			case (sink_style)
				0: res_if.ready <= 1'b1;
				1: res_if.ready <= ($urandom_range(0, 3) != 0);
				2: begin
					if ($urandom_range(0, 5) == 0) begin
						res_if.ready <= 1'b0;
						stall_left <= $urandom_range(1, 7);
					end else begin
						res_if.ready <= 1'b1;
					end
				end
				default: begin
					if ($urandom_range(0, 11) == 0) begin
						res_if.ready <= 1'b0;
						stall_left <= $urandom_range(9, 19);
					end else begin
						res_if.ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// sender: one word, with a random gap ahead of each burst
	task automatic send_word(input operand_word_t w);
		int gap;
		if (burst_left == 0) begin
			// now and then a long stretch with no gaps at all
			if ($urandom_range(0, 7) == 0) begin
				gap = 0;
				burst_left = $urandom_range(30, 60);
			end else begin
				gap = $urandom_range(0, 6);
				burst_left = $urandom_range(1, 12);
			end
			repeat (gap) begin
				@(negedge clk);
				opnd_if.valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		opnd_if.valid           <= 1'b1;
		opnd_if.mode            <= w.mode;
		opnd_if.left_has_stats  <= w.lhs;
		opnd_if.left_can_null   <= w.lnull;
		opnd_if.left_integral   <= w.lint;
		opnd_if.left_min        <= w.lmin;
		opnd_if.left_max        <= w.lmax;
		opnd_if.right_has_stats <= w.rhs;
		opnd_if.right_can_null  <= w.rnull;
		opnd_if.right_integral  <= w.rint;
		opnd_if.right_min       <= w.rmin;
		opnd_if.right_max       <= w.rmax;
		do
			@(posedge clk);
		while (!opnd_if.ready);
		expected_ranges.push_back(predict_range(w));
		words_sent++;
		mode_count[w.mode]++;
	endtask

	task automatic wait_results_drained();
		while (expected_ranges.size() > 0)
			@(posedge clk);
	endtask

	// hold valid low and let the pipeline empty
	task automatic pause_until_drained();
		@(negedge clk);
		opnd_if.valid <= 1'b0;
		burst_left = 0;
		wait_results_drained();
	endtask

	function automatic operand_word_t make_word(
		input logic [ib_pkg::MODE_W-1:0] mode,
		input logic lhs, input logic lnull, input logic lint,
		input logic [IN_W-1:0] lmin, input logic [IN_W-1:0] lmax,
		input logic rhs, input logic rnull, input logic rint,
		input logic [IN_W-1:0] rmin, input logic [IN_W-1:0] rmax);
		operand_word_t w;
		w.mode = mode;
		w.lhs = lhs; w.lnull = lnull; w.lint = lint; w.lmin = lmin; w.lmax = lmax;
		w.rhs = rhs; w.rnull = rnull; w.rint = rint; w.rmin = rmin; w.rmax = rmax;
		return w;
	endfunction

	// bound picker: full random, small, extremes and near zero
	function automatic logic [IN_W-1:0] pick_bound();
		case ($urandom_range(0, 6))
			0, 1: return $urandom;
			2:    return IN_W'($urandom_range(0, 40)) - IN_W'(20);
			3:    return BOUND_MIN;
			4:    return BOUND_MAX;
			5:    return IN_W'($urandom_range(0, 2)) - IN_W'(1);
			default: return $urandom >> $urandom_range(0, IN_W - 1);
		endcase
	endfunction

	function automatic operand_word_t random_word(input int mode_lo, input int mode_hi,
		input int pct_clean);
		operand_word_t w;
		logic [IN_W-1:0] t;
		w.mode = ib_pkg::MODE_W'($urandom_range(mode_lo, mode_hi));
		if ($urandom_range(0, 99) < pct_clean) begin
			w.lhs = 1'b1; w.rhs = 1'b1; w.lint = 1'b1; w.rint = 1'b1;
		end else begin
			w.lhs = 1'($urandom); w.rhs = 1'($urandom);
			w.lint = 1'($urandom); w.rint = 1'($urandom);
		end
		w.lnull = 1'($urandom);
		w.rnull = 1'($urandom);
		w.lmin = pick_bound(); w.lmax = pick_bound();
		w.rmin = pick_bound(); w.rmax = pick_bound();
		// mostly ordered ranges, some left reversed
		if ($urandom_range(0, 4) != 0 && $signed(w.lmin) > $signed(w.lmax)) begin
			t = w.lmin; w.lmin = w.lmax; w.lmax = t;
		end
		if ($urandom_range(0, 4) != 0 && $signed(w.rmin) > $signed(w.rmax)) begin
			t = w.rmin; w.rmin = w.rmax; w.rmax = t;
		end
		return w;
	endfunction

	// ------------------------------------------------------------------
	// tests
	task automatic test_corner_extremes();
		int m;
		send_word(make_word(ib_pkg::MODE_ADD, 1, 0, 1, BOUND_MIN, BOUND_MAX,
			1, 0, 1, BOUND_MIN, BOUND_MAX));
		send_word(make_word(ib_pkg::MODE_SUB, 1, 0, 1, BOUND_MIN, BOUND_MAX,
			1, 0, 1, BOUND_MIN, BOUND_MAX));
		send_word(make_word(ib_pkg::MODE_MUL, 1, 0, 1, BOUND_MIN, BOUND_MAX,
			1, 0, 1, BOUND_MIN, BOUND_MAX));
		send_word(make_word(ib_pkg::MODE_MUL, 1, 1, 1, BOUND_MIN, BOUND_MIN,
			1, 1, 1, BOUND_MIN, BOUND_MIN));
		send_word(make_word(ib_pkg::MODE_MUL, 1, 0, 1, BOUND_MAX, BOUND_MAX,
			1, 0, 1, BOUND_MIN, BOUND_MAX));
		// reversed ranges keep the corner rule
		send_word(make_word(ib_pkg::MODE_ADD, 1, 0, 1, 32'sd100, -32'sd100,
			1, 0, 1, 32'sd3, 32'sd7));
		send_word(make_word(ib_pkg::MODE_SUB, 1, 1, 0, -32'sd4, 32'sd9,
			1, 0, 0, 32'sd50, -32'sd50));
		send_word(make_word(ib_pkg::MODE_MUL, 1, 1, 1, -32'sd5, 32'sd7,
			1, 1, 1, -32'sd3, 32'sd2));
		// divide: divisor spanning zero, touching zero, clear of zero
		send_word(make_word(ib_pkg::MODE_DIV, 1, 0, 1, BOUND_MIN, BOUND_MAX,
			1, 0, 1, -32'sd1, 32'sd1));
		send_word(make_word(ib_pkg::MODE_DIV, 1, 1, 1, -32'sd9, 32'sd4,
			1, 0, 1, 32'sd1, 32'sd10));
		send_word(make_word(ib_pkg::MODE_DIV, 1, 0, 1, 32'sd6, 32'sd12,
			1, 0, 1, 32'sd0, 32'sd0));
		send_word(make_word(ib_pkg::MODE_DIV, 1, 0, 1, 32'sd3, 32'sd5,
			1, 0, 1, 32'sd5, -32'sd5));
		send_word(make_word(ib_pkg::MODE_DIV, 1, 0, 1, BOUND_MIN, BOUND_MIN,
			1, 0, 1, 32'sd2, 32'sd3));
		// divide with a non-integral side drops stats
		send_word(make_word(ib_pkg::MODE_DIV, 1, 1, 0, 32'sd1, 32'sd2,
			1, 1, 1, -32'sd1, 32'sd1));
		send_word(make_word(ib_pkg::MODE_DIV, 1, 1, 1, 32'sd1, 32'sd2,
			1, 1, 0, 32'sd1, 32'sd2));
		// modulo: zero-spanning divisor does not flag null
		send_word(make_word(ib_pkg::MODE_MOD, 1, 0, 1, 32'sd10, 32'sd20,
			1, 0, 1, -32'sd5, 32'sd5));
		send_word(make_word(ib_pkg::MODE_MOD, 1, 0, 0, 32'sd10, 32'sd20,
			1, 1, 0, BOUND_MAX, BOUND_MIN));
		send_word(make_word(ib_pkg::MODE_MOD, 1, 1, 1, BOUND_MIN, BOUND_MAX,
			1, 0, 1, 32'sd0, BOUND_MAX));
		// missing stats on either side
		send_word(make_word(ib_pkg::MODE_ADD, 0, 1, 1, 32'sd1, 32'sd2,
			1, 1, 1, 32'sd3, 32'sd4));
		send_word(make_word(ib_pkg::MODE_MUL, 1, 1, 1, 32'sd1, 32'sd2,
			0, 1, 1, 32'sd3, 32'sd4));
		// unused mode codes
		for (m = ib_pkg::MODE_MOD + 1; m < MODE_CODES; m++)
			send_word(make_word(ib_pkg::MODE_W'(m), 1, 1, 1, -32'sd1, 32'sd1,
				1, 1, 1, -32'sd1, 32'sd1));
		send_word(make_word(ib_pkg::MODE_SUB, 1, 1, 1, -32'sd1, 32'sd0,
			1, 1, 1, -32'sd1, 32'sd0));
	endtask

	task automatic test_random_ranges(input int count);
		repeat (count)
			send_word(random_word(ib_pkg::MODE_ADD, ib_pkg::MODE_MOD, 85));
	endtask

	// divide and modulo with small divisor ranges around zero
	task automatic test_divide_modulo(input int count);
		operand_word_t w;
		repeat (count) begin
			w = random_word(ib_pkg::MODE_DIV, ib_pkg::MODE_MOD, 75);
			if ($urandom_range(0, 1) == 0) begin
				w.rmin = IN_W'($urandom_range(0, 6)) - IN_W'(3);
				w.rmax = IN_W'($urandom_range(0, 6)) - IN_W'(3);
			end
			send_word(w);
		end
	endtask

	// flags and mode codes at random, unused codes included
	task automatic test_flag_noise(input int count);
		repeat (count)
			send_word(random_word(0, MODE_CODES - 1, 30));
	endtask

	// ------------------------------------------------------------------
	initial begin
		arst_n                  = 1'b0;
		opnd_if.valid           = 1'b0;
		opnd_if.mode            = '0;
		opnd_if.left_has_stats  = 1'b0;
		opnd_if.left_can_null   = 1'b0;
		opnd_if.left_integral   = 1'b0;
		opnd_if.left_min        = '0;
		opnd_if.left_max        = '0;
		opnd_if.right_has_stats = 1'b0;
		opnd_if.right_can_null  = 1'b0;
		opnd_if.right_integral  = 1'b0;
		opnd_if.right_min       = '0;
		opnd_if.right_max       = '0;
		res_if.ready            = 1'b0;
		foreach (mode_count[i])
			mode_count[i] = 0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_corner_extremes();
		pause_until_drained();
		test_random_ranges(350);
		pause_until_drained();
		test_divide_modulo(150);
		test_flag_noise(100);

		@(negedge clk);
		opnd_if.valid <= 1'b0;
		wait_results_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_ranges.size() != 0)
			report_error($sformatf("%0d results never arrived", expected_ranges.size()));

		$display("covered %0d operand words, %0d result words checked, %0d cycles",
			words_sent, words_seen, cycle_count);
		$display("per mode: add %0d sub %0d mul %0d div %0d mod %0d unused %0d",
			mode_count[ib_pkg::MODE_ADD], mode_count[ib_pkg::MODE_SUB],
			mode_count[ib_pkg::MODE_MUL], mode_count[ib_pkg::MODE_DIV],
			mode_count[ib_pkg::MODE_MOD],
			words_sent - mode_count[ib_pkg::MODE_ADD] - mode_count[ib_pkg::MODE_SUB]
			- mode_count[ib_pkg::MODE_MUL] - mode_count[ib_pkg::MODE_DIV]
			- mode_count[ib_pkg::MODE_MOD]);
		if (errors == 0)
			$display("interval_bounds_arith regression: pass");
		else
			$display("interval_bounds_arith regression: fail");
		$finish;
	end

endmodule
